>>> hw/rtl/tpfc_pkg.sv
// Shared types, register codes, reset values and fixed-point helpers for the force controller.
package tpfc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int FX_W      = 32;
    localparam int LIM_W     = 31;
    localparam int CFG_IDX_W = 3;

    typedef logic signed [FX_W-1:0] t_fx;
    typedef logic [LIM_W-1:0]       t_lim;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP_GAIN    = 3'd0,
        CFG_KI_GAIN    = 3'd1,
        CFG_KD_GAIN    = 3'd2,
        CFG_XY_LIMIT   = 3'd3,
        CFG_Z_LIMIT    = 3'd4,
        CFG_GRAVITY    = 3'd5
    } t_cfg_idx;

    localparam t_fx  RST_KP_GAIN = 32'sd65536;
    localparam t_fx  RST_KI_GAIN = 32'sd0;
    localparam t_fx  RST_KD_GAIN = 32'sd0;
    localparam t_lim RST_LIMIT   = 31'd327680;
    localparam t_fx  RST_GRAVITY = 32'sd243860;

    localparam t_fx FX_MAX = {1'b0, {(FX_W-1){1'b1}}};
    localparam t_fx FX_MIN = {1'b1, {(FX_W-1){1'b0}}};

    typedef struct packed {
        t_fx kp;
        t_fx ki;
        t_fx kd;
    } t_gains;

    typedef struct packed {
        t_fx current_x;
        t_fx current_y;
        t_fx current_z;
        t_fx target_x;
        t_fx target_y;
        t_fx target_z;
        t_fx vel_x;
        t_fx vel_y;
        t_fx vel_z;
    } t_in_item;

    typedef struct packed {
        t_fx force_x;
        t_fx force_y;
        t_fx force_z;
    } t_out_item;

    // Saturate a 64-bit signed value to 32 bits.
    function automatic t_fx sat_wide(input logic signed [63:0] v);
        if (v[63:FX_W-1] == '0 || v[63:FX_W-1] == '1) begin
            return t_fx'(v[FX_W-1:0]);
        end
        return v[63] ? FX_MIN : FX_MAX;
    endfunction

    function automatic t_fx add_sat(input t_fx a, input t_fx b);
        logic signed [FX_W:0] s;
        s = (FX_W+1)'(a) + (FX_W+1)'(b);
        if (s[FX_W] != s[FX_W-1]) begin
            return s[FX_W] ? FX_MIN : FX_MAX;
        end
        return t_fx'(s[FX_W-1:0]);
    endfunction

    function automatic t_fx sub_sat(input t_fx a, input t_fx b);
        logic signed [FX_W:0] s;
        s = (FX_W+1)'(a) - (FX_W+1)'(b);
        if (s[FX_W] != s[FX_W-1]) begin
            return s[FX_W] ? FX_MIN : FX_MAX;
        end
        return t_fx'(s[FX_W-1:0]);
    endfunction

    // Signed fixed-point product, floored back to the fixed-point grid and saturated.
    function automatic t_fx fx_mul(input t_fx a, input t_fx b);
        logic signed [2*FX_W-1:0] p;
        p = a * b;
        return sat_wide(p >>> FRAC_BITS);
    endfunction

    function automatic t_fx clamp_sym(input t_fx v, input t_lim lim);
        t_fx l;
        l = $signed({1'b0, lim});
        if (v > l) begin
            return l;
        end
        if (v < -l) begin
            return -l;
        end
        return v;
    endfunction

    // Leaky integral: (3 * error + old) / 4, floored and saturated.
    function automatic t_fx leak_integ(input t_fx err, input t_fx old);
        logic signed [FX_W+2:0] s;
        s = ((FX_W+3)'(err) <<< 1) + (FX_W+3)'(err) + (FX_W+3)'(old);
        return sat_wide(64'(s >>> 2));
    endfunction

endpackage

>>> hw/rtl/three_axis_pid_force_controller.sv
// Top level of the three-axis PID force controller with leaky integral and anti-windup.
//
//   Channel  Direction  Handshake                     Payload
//   in       input      i_in_valid / o_in_stall       i_in_item  (t_in_item)
//   out      output     o_out_valid / i_out_stall     o_out_item (t_out_item)
//   cfg      input      i_cfg_we (no back-pressure)   i_cfg_idx, i_cfg_data
//
// One item is accepted per clock cycle when the output side keeps up; each item
// passes through the input register, then the result register, before its result shows.
// All the arithmetic for an item sits between those two registers, and the per-axis
// state is updated as the item enters the result register.
// Reset is synchronous and active low; it clears the pipeline, the axis state and
// loads the register defaults.
// A stall on the output holds the result register; the input register then fills and
// o_in_stall rises, so no item is lost.
module three_axis_pid_force_controller import tpfc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_item,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [FX_W-1:0]      i_cfg_data
);

    // Configuration registers.
    t_fx  r_kp;
    t_fx  r_ki;
    t_fx  r_kd;
    t_lim r_xy_limit;
    t_lim r_z_limit;
    t_fx  r_gravity;

    // Pipeline registers.
    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_out_item n_out_item;

    logic   in_acc;
    logic   out_acc;
    logic   advance;
    t_gains gains;
    t_fx    force_x;
    t_fx    force_y;
    t_fx    force_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp       <= RST_KP_GAIN;
            r_ki       <= RST_KI_GAIN;
            r_kd       <= RST_KD_GAIN;
            r_xy_limit <= RST_LIMIT;
            r_z_limit  <= RST_LIMIT;
            r_gravity  <= RST_GRAVITY;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KP_GAIN:  r_kp       <= t_fx'(i_cfg_data);
                CFG_KI_GAIN:  r_ki       <= t_fx'(i_cfg_data);
                CFG_KD_GAIN:  r_kd       <= t_fx'(i_cfg_data);
                CFG_XY_LIMIT: r_xy_limit <= i_cfg_data[LIM_W-1:0];
                CFG_Z_LIMIT:  r_z_limit  <= i_cfg_data[LIM_W-1:0];
                CFG_GRAVITY:  r_gravity  <= t_fx'(i_cfg_data);
                default: begin
                    // Unused indexes are ignored.
                end
            endcase
        end
    end

    // The item in the input register moves on whenever the result register is free
    // or is being emptied in the same cycle.
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && r_out_valid && i_out_stall;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_acc    = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_item <= i_in_item;
        end
    end

    assign gains = '{kp: r_kp, ki: r_ki, kd: r_kd};

    tpfc_axis u_axis_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (advance),
        .i_cur   (r_in_item.current_x),
        .i_tgt   (r_in_item.target_x),
        .i_vel   (r_in_item.vel_x),
        .i_lim   (r_xy_limit),
        .i_gains (gains),
        .o_force (force_x)
    );

    tpfc_axis u_axis_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (advance),
        .i_cur   (r_in_item.current_y),
        .i_tgt   (r_in_item.target_y),
        .i_vel   (r_in_item.vel_y),
        .i_lim   (r_xy_limit),
        .i_gains (gains),
        .o_force (force_y)
    );

    tpfc_axis u_axis_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (advance),
        .i_cur   (r_in_item.current_z),
        .i_tgt   (r_in_item.target_z),
        .i_vel   (r_in_item.vel_z),
        .i_lim   (r_z_limit),
        .i_gains (gains),
        .o_force (force_z)
    );

    // Gravity compensation applies to Z only, after the limit.
    always_comb begin
        n_out_item.force_x = force_x;
        n_out_item.force_y = force_y;
        n_out_item.force_z = add_sat(force_z, r_gravity);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (out_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // An accepted item always lands in the input register.
    a_in_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_in_valid)
        else $error("accepted item did not reach the input register");

    // An item that leaves the input register always shows up as a result.
    a_adv_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("advanced item did not reach the result register");

    // With an empty result register the input side is never held off.
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> !o_in_stall)
        else $error("input stalled while the result register is empty");

    // The X force of a waiting result lies within the XY limit.
    a_x_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_item.force_x <= $signed({1'b0, r_xy_limit})) &&
                        (r_out_item.force_x >= -$signed({1'b0, r_xy_limit})))
        else $error("X force outside its limit");

endmodule

>>> hw/rtl/tpfc_axis.sv
// One axis of the controller: error, leaky integral, clamped PD and PID terms, axis state.
module tpfc_axis import tpfc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_upd,
    input  t_fx    i_cur,
    input  t_fx    i_tgt,
    input  t_fx    i_vel,
    input  t_lim   i_lim,
    input  t_gains i_gains,
    output t_fx    o_force
);

    t_fx r_prev_err;
    t_fx r_integ;
    t_fx n_prev_err;
    t_fx n_integ;

    t_fx err;
    t_fx diff;
    t_fx integ;
    t_fx p_term;
    t_fx d_term;
    t_fx i_term;
    t_fx pd_raw;
    t_fx pd_sum;
    t_fx pd_clamp;
    t_fx out_sum;
    t_fx out_clamp;

    // The three products are independent, so they run side by side.
    always_comb begin
        err       = sub_sat(i_tgt, i_cur);
        diff      = sub_sat(err, r_prev_err);
        integ     = leak_integ(err, r_integ);
        p_term    = fx_mul(i_gains.kp, err);
        d_term    = fx_mul(i_gains.kd, diff);
        i_term    = fx_mul(i_gains.ki, integ);
        pd_raw    = sub_sat(p_term, i_vel);
        pd_sum    = add_sat(pd_raw, d_term);
        pd_clamp  = clamp_sym(pd_sum, i_lim);
        out_sum   = add_sat(pd_clamp, i_term);
        out_clamp = clamp_sym(out_sum, i_lim);
        // Anti-windup: the integral keeps only what the limited output really used.
        n_integ    = sub_sat(out_clamp, pd_clamp);
        n_prev_err = err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_err <= '0;
            r_integ    <= '0;
        end else if (i_upd) begin
            r_prev_err <= n_prev_err;
            r_integ    <= n_integ;
        end
    end

    assign o_force = out_clamp;

endmodule
